/* rtl/zfp_block_decompress_4x32_defines.svh */
// Assertion macros for the block decompressor RTL.
// Included by every module that carries concurrent assertions.
`ifndef ZFP_BLOCK_DECOMPRESS_4X32_DEFINES_SVH
`define ZFP_BLOCK_DECOMPRESS_4X32_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on each rising edge, skipped while reset is high.
`define ZFPBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on each rising edge, reset included.
`define ZFPBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZFPBD_ASSERT(lbl, clk, rst, prop, msg)
`define ZFPBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/zfpbd_pkg.sv */
// Shared constants, types and float helpers for the block decompressor.
// No dependencies.
`timescale 1ns / 1ps
package zfpbd_pkg;

  localparam int          ExpBits     = 8 + 1;
  localparam int          ExpBias     = (1 << (8 - 1)) - 1;
  localparam int          FracPos     = 32 - 2;
  localparam logic [31:0] NegaMask    = 32'haaaaaaaa;
  localparam logic [3:0]  BudgetReset = 4'd11;
  localparam logic [31:0] QuietNan    = 32'h7FC00000;
  localparam logic [30:0] InfMag      = 31'h7F800000;
  localparam int          NumLanes    = 4;

  // register index of the coefficient width register
  localparam logic RegCoefBits = 1'b0;

  typedef logic [31:0] word_t;
  typedef word_t [NumLanes-1:0] lanes_t;

  // normalized magnitude of one integer
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [5:0]  msb;
    logic [23:0] mant;
  } norm_t;

  typedef norm_t [NumLanes-1:0] norm_lanes_t;

  // shift right by r (r >= 1), round to nearest, ties to even
  function automatic logic [31:0] shr_rne(input logic [31:0] x, input logic [4:0] r);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    q    = x >> r;
    rem  = x & ((32'd1 << r) - 32'd1);
    half = 32'd1 << (r - 5'd1);
    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
    return q;
  endfunction

  // two's complement integer to sign, msb index and 24-bit mantissa
  function automatic norm_t normalize(input logic [31:0] v);
    norm_t       n;
    logic [31:0] a;
    logic [31:0] q;
    logic [5:0]  p;
    a = v[31] ? (32'd0 - v) : v;
    p = 6'd0;
    for (int j = 0; j < 32; j++) begin
      if (a[j]) p = 6'(j);
    end
    n.sign = v[31];
    n.zero = (a == 32'd0);
    if (p > 6'd23) begin
      q = shr_rne(a, 5'(p - 6'd23));
      if (q == 32'h1000000) begin
        q = q >> 1;
        p = p + 6'd1;
      end
    end else begin
      q = a << (6'd23 - p);
    end
    n.msb  = p;
    n.mant = q[23:0];
    return n;
  endfunction

endpackage

/* rtl/zfp_block_decompress_4x32.sv */
// Top level of the fixed-rate 1-D block decompressor: APB register, pipeline.
// Depends on zfpbd_pkg, zfpbd_unpack, zfpbd_lift, zfpbd_scale and the macro header.
// A block taken at one edge passes six register stages (capture, unpack, lift mid and out,
// scale mid and out) and then shows on value0..value3 with done.
// Throughput: one block per cycle; busy stays low and the pipeline never stalls.
// Reset: synchronous rst clears all valid bits and sets coef_bits to 11.
// Results are held for exactly one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`include "zfp_block_decompress_4x32_defines.svh"
module zfp_block_decompress_4x32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] compressed_word,
  output logic        done,
  output logic [31:0] value0,
  output logic [31:0] value1,
  output logic [31:0] value2,
  output logic [31:0] value3,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]         coef_bits;
  logic               in_valid;
  logic [63:0]        word;
  logic [3:0]         budget;
  logic               up_valid;
  zfpbd_pkg::lanes_t  coef;
  logic signed [10:0] up_exp;
  logic               lf_valid;
  zfpbd_pkg::lanes_t  ints;
  logic signed [10:0] lf_exp;
  zfpbd_pkg::lanes_t  value;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == zfpbd_pkg::RegCoefBits) ? {28'b0, coef_bits} : 32'd0;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_bits <= zfpbd_pkg::BudgetReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == zfpbd_pkg::RegCoefBits) begin
      coef_bits <= pwdata[3:0];
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else     in_valid <= start && !busy;
  end

  always_ff @(posedge clk) begin
    word   <= compressed_word;
    budget <= coef_bits;
  end

  zfpbd_unpack u_unpack (
    .clk(clk), .rst(rst), .in_valid(in_valid), .word(word), .budget(budget),
    .out_valid(up_valid), .coef(coef), .scale_exp(up_exp)
  );

  zfpbd_lift u_lift (
    .clk(clk), .rst(rst), .in_valid(up_valid), .coef(coef), .in_exp(up_exp),
    .out_valid(lf_valid), .ints(ints), .out_exp(lf_exp)
  );

  zfpbd_scale u_scale (
    .clk(clk), .rst(rst), .in_valid(lf_valid), .ints(ints), .in_exp(lf_exp),
    .out_valid(done), .value(value)
  );

  assign value0 = value[0];
  assign value1 = value[1];
  assign value2 = value[2];
  assign value3 = value[3];

  `ZFPBD_ASSERT(a_done_latency, clk, rst, (done |-> $past(start, 6)), "result without a block six cycles earlier")
  `ZFPBD_ASSERT_ALWAYS(a_quiet_after_reset, clk, (rst |=> !done), "result right after reset")

endmodule

/* rtl/zfpbd_unpack.sv */
// Field extraction and negabinary decode of one compressed block.
// Depends on zfpbd_pkg.
`timescale 1ns / 1ps
module zfpbd_unpack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [63:0]          word,
  input  logic [3:0]           budget,
  output logic                 out_valid,
  output zfpbd_pkg::lanes_t    coef,
  output logic signed [10:0]   scale_exp
);

  zfpbd_pkg::lanes_t coef_next;
  logic [14:0]       mask;
  logic [8:0]        bexp;

  assign mask = 15'h7fff >> (4'd15 - budget);
  assign bexp = word[zfpbd_pkg::ExpBits-1:0];

  // pull flag and bits of each group and decode from negabinary
  for (genvar i = 0; i < zfpbd_pkg::NumLanes; i++) begin : g_lane
    logic [5:0]  pos;
    logic [79:0] ext;
    logic [14:0] raw;
    logic [4:0]  sh;
    logic [31:0] u;
    assign pos = 6'd9 + 6'(i) * (6'({2'b0, budget}) + 6'd1);
    assign ext = {16'b0, word} >> pos;
    assign raw = ext[15:1] & mask;
    assign sh  = ext[0] ? 5'(6'd32 - {2'b0, budget}) : 5'(6'd28 - {2'b0, budget});
    assign u   = (budget == 4'd0) ? 32'd0 : ({17'b0, raw} << sh);
    assign coef_next[i] = (u ^ zfpbd_pkg::NegaMask) - zfpbd_pkg::NegaMask;
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  // hold coefficients and scale exponent
  always_ff @(posedge clk) begin
    coef      <= coef_next;
    scale_exp <= 11'($signed({2'b0, bexp})) - 11'(zfpbd_pkg::ExpBias + zfpbd_pkg::FracPos);
  end

endmodule

/* rtl/zfpbd_lift.sv */
// Two-stage 32-bit wrapping inverse lifting of four coefficients.
// Depends on zfpbd_pkg.
`timescale 1ns / 1ps
module zfpbd_lift (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  zfpbd_pkg::lanes_t    coef,
  input  logic signed [10:0]   in_exp,
  output logic                 out_valid,
  output zfpbd_pkg::lanes_t    ints,
  output logic signed [10:0]   out_exp
);

  logic                     mid_valid;
  zfpbd_pkg::lanes_t        mid;
  logic signed [10:0]       mid_exp;
  zfpbd_pkg::lanes_t        mid_next;
  zfpbd_pkg::lanes_t        ints_next;

  // first half: update y and w
  always_comb begin
    logic [31:0] y, w;
    y = coef[1] + {coef[3][31], coef[3][31:1]};
    w = coef[3] - {y[31], y[31:1]};
    y = y + w;
    w = (w << 1) - y;
    mid_next = coef;
    mid_next[1] = y;
    mid_next[3] = w;
  end

  // second half: mix all four
  always_comb begin
    logic [31:0] x, y, z, w;
    x = mid[0]; y = mid[1]; z = mid[2]; w = mid[3];
    z = z + x; x = (x << 1) - z;
    y = y + z; z = (z << 1) - y;
    w = w + x; x = (x << 1) - w;
    ints_next[0] = x; ints_next[1] = y; ints_next[2] = z; ints_next[3] = w;
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  // hold data
  always_ff @(posedge clk) begin
    mid     <= mid_next;
    mid_exp <= in_exp;
    ints    <= ints_next;
    out_exp <= mid_exp;
  end

endmodule

/* rtl/zfpbd_scale.sv */
// Integer to single conversion and scaling by 2^k, two stages.
// Depends on zfpbd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "zfp_block_decompress_4x32_defines.svh"
module zfpbd_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  zfpbd_pkg::lanes_t    ints,
  input  logic signed [10:0]   in_exp,
  output logic                 out_valid,
  output zfpbd_pkg::lanes_t    value
);

  logic                       mid_valid;
  zfpbd_pkg::norm_lanes_t     norm;
  logic signed [10:0]         mid_exp;
  zfpbd_pkg::lanes_t          value_next;

  // apply exponent, handle overflow, underflow and subnormals
  for (genvar i = 0; i < zfpbd_pkg::NumLanes; i++) begin : g_lane
    always_comb begin
      logic signed [10:0] e;
      logic [4:0]         r;
      logic [31:0]        q;
      e = $signed({5'b0, norm[i].msb}) + mid_exp;
      r = 5'(-(e + 11'sd126));
      q = zfpbd_pkg::shr_rne({8'b0, norm[i].mant}, r);
      if (mid_exp > 11'sd127) begin
        value_next[i] = norm[i].zero ? zfpbd_pkg::QuietNan
                                     : {norm[i].sign, zfpbd_pkg::InfMag};
      end else if (mid_exp < -11'sd149 || norm[i].zero) begin
        value_next[i] = {norm[i].sign, 31'b0};
      end else if (e > 11'sd127) begin
        value_next[i] = {norm[i].sign, zfpbd_pkg::InfMag};
      end else if (e >= -11'sd126) begin
        value_next[i] = {norm[i].sign, 8'(e + 11'sd127), norm[i].mant[22:0]};
      end else begin
        value_next[i] = {norm[i].sign, q[30:0]};
      end
    end
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  // hold normalized magnitudes and results
  always_ff @(posedge clk) begin
    for (int i = 0; i < zfpbd_pkg::NumLanes; i++) begin
      norm[i] <= zfpbd_pkg::normalize(ints[i]);
    end
    mid_exp <= in_exp;
    value   <= value_next;
  end

  `ZFPBD_ASSERT(a_nan_only_quiet, clk, rst, (out_valid |-> !(value[0][30:23] == 8'hFF && value[0][22:0] != 23'd0 && value[0] != zfpbd_pkg::QuietNan)), "unexpected NaN pattern")
  `ZFPBD_ASSERT(a_two_stage, clk, rst, (out_valid |-> $past(in_valid, 2)), "scale result without source")

endmodule
